[rtl/slcp_pkg.sv]
`default_nettype none

package slcp_pkg;

   // Result action codes as they appear on the result channel.
   typedef enum logic [3:0] {
      ACT_END_ACK   = 4'd0,
      ACT_SET_ALL   = 4'd1,
      ACT_SET_ONE   = 4'd2,
      ACT_SET_RANGE = 4'd3,
      ACT_START_ACK = 4'd4,
      ACT_RED       = 4'd5,
      ACT_GREEN     = 4'd6,
      ACT_BLUE      = 4'd7,
      ACT_WHITE     = 4'd8,
      ACT_OFF       = 4'd9,
      ACT_TOGGLE    = 4'd10,
      ACT_BREATHE   = 4'd11,
      ACT_STATIC    = 4'd12,
      ACT_RAINBOW   = 4'd13
   } action_type;

   localparam logic [7:0] CH_LF     = 8'd10;
   localparam logic [7:0] CH_CR     = 8'd13;
   localparam logic [7:0] CH_COMMA  = 8'h2C;
   localparam logic [7:0] CH_PERIOD = 8'h2E;
   localparam logic [7:0] CH_ZERO   = 8'h30;
   localparam logic [7:0] CH_NINE   = 8'h39;
   localparam logic [7:0] CH_CMD    = 8'h43;
   localparam logic [7:0] CH_RED    = 8'h72;
   localparam logic [7:0] CH_GREEN  = 8'h67;
   localparam logic [7:0] CH_BLUE   = 8'h62;
   localparam logic [7:0] CH_WHITE  = 8'h77;
   localparam logic [7:0] CH_OFF    = 8'h6F;
   localparam logic [7:0] CH_TOGGLE = 8'h54;
   localparam logic [7:0] CH_BREATH = 8'h50;
   localparam logic [7:0] CH_STATIC = 8'h53;
   localparam logic [7:0] CH_RAINBW = 8'h55;

   localparam int         MAX_VALUES  = 5;
   localparam int         MAX_RESULTS = 3;
   localparam logic [2:0] VALUES_FULL = 3'd5;
   localparam logic [7:0] LED_COUNT_RESET = 8'd16;

   typedef struct packed {
      action_type action;
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [7:0] first_led;
      logic [7:0] end_led;
      logic       last;
   } result_type;

   typedef struct packed {
      logic                             collecting;
      logic [2:0]                       value_count;
      logic [1:0]                       digit_count;
      logic [2:0][3:0]                  digit_buffer;
      logic [MAX_VALUES-1:0][7:0]       values;
   } state_type;

endpackage

`default_nettype wire

[rtl/slcp_req_if.sv]
`default_nettype none

interface slcp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

[rtl/slcp_rsp_if.sv]
`default_nettype none

interface slcp_rsp_if;
   logic       valid;
   logic       ready;
   logic [3:0] action;
   logic [7:0] red;
   logic [7:0] green;
   logic [7:0] blue;
   logic [7:0] first_led;
   logic [7:0] end_led;
   logic       last;

   modport source (output valid, output action, output red, output green, output blue,
                   output first_led, output end_led, output last, input ready);
   modport sink   (input valid, input action, input red, input green, input blue,
                   input first_led, input end_led, input last, output ready);
endinterface

`default_nettype wire

[rtl/slcp_decode.sv]
`default_nettype none

// Per-byte parser step: next parser state and up to three results.
module slcp_decode (
   input  wire logic [7:0]                          rx_byte,
   input  wire logic [7:0]                          led_count,
   input  wire slcp_pkg::state_type                 state,
   output slcp_pkg::state_type                      next_state,
   output slcp_pkg::result_type [2:0]               results,
   output logic [1:0]                               result_count
);
   import slcp_pkg::*;

   logic       is_digit;
   logic       finish;
   logic       still_collecting;
   logic       do_store;
   logic       has_act;
   action_type idle_act;
   logic [1:0] dc_new;
   logic [2:0][3:0] buf_new;
   logic [9:0] value_sum;
   logic [7:0] pos_s;
   logic [7:0] pos_e;
   result_type set_res;
   logic       has_set;
   logic [1:0] n;

   always_comb begin
      is_digit = (rx_byte >= CH_ZERO) && (rx_byte <= CH_NINE);
      finish   = state.collecting &&
                 ((rx_byte == CH_LF) || (rx_byte == CH_CR) || (state.value_count >= VALUES_FULL));
      still_collecting = state.collecting && !finish;

      next_state = state;
      if (finish) begin
         next_state.collecting = 1'b0;
      end

      // Digit capture, then an optional store of the finished value.
      buf_new = state.digit_buffer;
      dc_new  = state.digit_count;
      if (is_digit) begin
         buf_new[state.digit_count] = rx_byte[3:0];
         dc_new = state.digit_count + 2'd1;
      end
      do_store = (((rx_byte == CH_COMMA) || (rx_byte == CH_PERIOD)) &&
                  (state.digit_count != 2'd0)) || (state.digit_count == 2'd2);

      unique case (dc_new)
         2'd1:    value_sum = {6'd0, buf_new[0]};
         2'd2:    value_sum = 10'({6'd0, buf_new[0]} * 10'd10) + {6'd0, buf_new[1]};
         2'd3:    value_sum = 10'({6'd0, buf_new[0]} * 10'd100) +
                              10'({6'd0, buf_new[1]} * 10'd10) + {6'd0, buf_new[2]};
         default: value_sum = 10'd0;
      endcase

      if (still_collecting) begin
         next_state.digit_buffer = buf_new;
         if (do_store) begin
            if ((dc_new != 2'd0) && (state.value_count < VALUES_FULL)) begin
               next_state.values[state.value_count] = value_sum[7:0];
               next_state.value_count = state.value_count + 3'd1;
            end
            next_state.digit_count = 2'd0;
         end else begin
            next_state.digit_count = dc_new;
         end
      end

      // Bytes seen while idle, including the byte that just ended a command.
      has_act  = 1'b1;
      idle_act = ACT_END_ACK;
      unique case (rx_byte)
         CH_CMD:    idle_act = ACT_START_ACK;
         CH_RED:    idle_act = ACT_RED;
         CH_GREEN:  idle_act = ACT_GREEN;
         CH_BLUE:   idle_act = ACT_BLUE;
         CH_WHITE:  idle_act = ACT_WHITE;
         CH_OFF:    idle_act = ACT_OFF;
         CH_TOGGLE: idle_act = ACT_TOGGLE;
         CH_BREATH: idle_act = ACT_BREATHE;
         CH_STATIC: idle_act = ACT_STATIC;
         CH_RAINBW: idle_act = ACT_RAINBOW;
         default:   has_act  = 1'b0;
      endcase
      if (still_collecting) begin
         has_act = 1'b0;
      end
      if (has_act && (idle_act == ACT_START_ACK)) begin
         next_state.collecting  = 1'b1;
         next_state.value_count = 3'd0;
         next_state.digit_count = 2'd0;
      end

      // Set action chosen at the end of a command.
      pos_s   = state.values[3];
      pos_e   = state.values[4];
      set_res = '0;
      set_res.action = ACT_SET_ALL;
      set_res.red    = state.values[0];
      set_res.green  = state.values[1];
      set_res.blue   = state.values[2];
      has_set = 1'b1;
      unique case (state.value_count)
         3'd3: has_set = 1'b1;
         3'd4: begin
            if (pos_s < led_count) begin
               set_res.action    = ACT_SET_ONE;
               set_res.first_led = pos_s;
            end
         end
         3'd5: begin
            if ((pos_e != 8'd0) && (pos_e <= led_count) && (pos_e > pos_s) &&
                (pos_s < led_count)) begin
               set_res.action    = ACT_SET_RANGE;
               set_res.first_led = pos_s;
               set_res.end_led   = pos_e;
            end
         end
         default: has_set = 1'b0;
      endcase

      results = '0;
      n = 2'd0;
      if (finish) begin
         results[0].action = ACT_END_ACK;
         n = 2'd1;
         if (has_set) begin
            results[1] = set_res;
            n = 2'd2;
         end
      end
      if (has_act) begin
         results[n].action = idle_act;
         n = n + 2'd1;
      end
      if (n != 2'd0) begin
         results[n - 2'd1].last = 1'b1;
      end
      result_count = n;
   end

endmodule

`default_nettype wire

[rtl/serial_led_command_parser.sv]
`default_nettype none

// Channel   Direction  Transfer when         Payload
// req_if    in         valid && ready        rx_byte
// rsp_if    out        valid && ready        action, red, green, blue, first_led, end_led, last
// csr_*     in         csr_we                led_count (8 bits)
//
// A byte is parsed in the cycle it is accepted and its zero to three results are
// loaded into a three-entry result register, from which they leave head first.
// A new byte is accepted when the result register is empty, or when its last
// result is being transferred in the same cycle, so while rsp_if is ready bytes
// with one result stream at one per cycle; further results each hold the output.
// Reset is synchronous: the parser goes idle, results are dropped, led_count is 16.
// A stall on rsp_if holds the head result and blocks new bytes once it has any
// result left that cannot leave this cycle.
module serial_led_command_parser (
   input  wire logic       clock,
   input  wire logic       reset,
   slcp_req_if.sink        req_if,
   slcp_rsp_if.source      rsp_if,
   input  wire logic       csr_we,
   input  wire logic [7:0] csr_wdata
);
   import slcp_pkg::*;

   // Configuration register.
   logic [7:0] led_count_ff;

   // Parser state, updated on every accepted byte.
   state_type state_ff;
   state_type state_in;

   // Result register, head in slot 0, and the number of results still held.
   result_type [2:0] slots_ff;
   result_type [2:0] slots_in;
   logic [1:0]       count_ff;
   logic [1:0]       count_in;

   result_type [2:0] step_results;
   logic [1:0]       step_count;
   logic             accept;
   logic             pop;

   slcp_decode u_decode (
      .rx_byte      (req_if.rx_byte),
      .led_count    (led_count_ff),
      .state        (state_ff),
      .next_state   (state_in),
      .results      (step_results),
      .result_count (step_count)
   );

   assign pop          = (count_ff != 2'd0) && rsp_if.ready;
   // The previous byte's results must all be gone by the end of this cycle.
   assign req_if.ready = (count_ff == 2'd0) || ((count_ff == 2'd1) && rsp_if.ready);
   assign accept       = req_if.valid && req_if.ready;

   always_comb begin
      slots_in = slots_ff;
      count_in = count_ff;
      if (accept) begin
         slots_in = step_results;
         count_in = step_count;
      end else if (pop) begin
         slots_in[0] = slots_ff[1];
         slots_in[1] = slots_ff[2];
         count_in    = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      // Digit and value stores carry no reset; every entry is written before it is read.
      if (accept) begin
         state_ff.digit_buffer <= state_in.digit_buffer;
         state_ff.values       <= state_in.values;
      end
      if (reset) begin
         led_count_ff         <= LED_COUNT_RESET;
         state_ff.collecting  <= 1'b0;
         state_ff.value_count <= 3'd0;
         state_ff.digit_count <= 2'd0;
         count_ff             <= 2'd0;
      end else begin
         if (csr_we) begin
            led_count_ff <= csr_wdata;
         end
         if (accept) begin
            state_ff.collecting  <= state_in.collecting;
            state_ff.value_count <= state_in.value_count;
            state_ff.digit_count <= state_in.digit_count;
         end
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      slots_ff <= slots_in;
   end

   assign rsp_if.valid     = (count_ff != 2'd0);
   assign rsp_if.action    = slots_ff[0].action;
   assign rsp_if.red       = slots_ff[0].red;
   assign rsp_if.green     = slots_ff[0].green;
   assign rsp_if.blue      = slots_ff[0].blue;
   assign rsp_if.first_led = slots_ff[0].first_led;
   assign rsp_if.end_led   = slots_ff[0].end_led;
   assign rsp_if.last      = slots_ff[0].last;

`ifndef SYNTH
   // The result count after an accepted byte is what the parser produced for it.
   a_load_count: assert property (@(posedge clock) disable iff (reset)
      accept |=> (count_ff == $past(step_count)))
      else $error("result count does not match the parsed byte");

   // Only the final held result of a byte carries the last flag.
   a_last_is_tail: assert property (@(posedge clock) disable iff (reset)
      ((count_ff != 2'd0) && slots_ff[0].last) |-> (count_ff == 2'd1))
      else $error("last flag set on a result that is not the tail");

   // A command always starts with empty counters.
   a_cmd_start: assert property (@(posedge clock) disable iff (reset)
      $rose(state_ff.collecting) |->
         ((state_ff.value_count == 3'd0) && (state_ff.digit_count == 2'd0)))
      else $error("command started with stale counters");

   // A third digit is always folded into a value in the same step.
   a_digit_bound: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff.digit_count != 2'd3))
      else $error("digit count left at three");
`endif

endmodule

`default_nettype wire
